// File: rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int NUM_FRAMES  = 1024;
  localparam int NUM_ORDERS  = 7;
  localparam int FRAME_BYTES = 4096;

  localparam int TOP_ORDER = NUM_ORDERS - 1;
  localparam int MAX_BLOCK = 1 << TOP_ORDER;
  localparam int LAST_TOP  = ((NUM_FRAMES - 1) / MAX_BLOCK) * MAX_BLOCK;

  localparam int AW      = $clog2(NUM_FRAMES);   // ram address
  localparam int LW      = AW + 1;               // link, holds the empty code
  localparam int FI_W    = AW + 2;               // frame index with headroom for sums
  localparam int PAGE_SH = $clog2(FRAME_BYTES);
  localparam int CNT_W   = NUM_ORDERS + 1;       // scan count and fill length
  localparam int MARK_W  = 4;

  localparam int FUNC_W  = 2;
  localparam int ORD_W   = 3;
  localparam int ADDR_W  = 22;
  localparam int BYTES_W = 23;
  localparam int STAT_W  = 2;
  localparam int UNIT_SH = PAGE_SH + NUM_ORDERS;
  localparam int RS_W    = BYTES_W + 2;

  localparam logic [LW-1:0]     NIL       = LW'(NUM_FRAMES);
  localparam logic [MARK_W-1:0] MARK_USED = 4'd14;
  localparam logic [MARK_W-1:0] MARK_BODY = 4'd15;
  localparam logic [CNT_W-1:0]  SCAN_LIM  = CNT_W'((1 << NUM_ORDERS) - 1);

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ORD_W-1:0]   order;
    logic [ADDR_W-1:0]  byte_addr;
    logic [BYTES_W-1:0] reserve_bytes;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_addr;
    logic [ORD_W-1:0]  freed_order;
  } resp_t;

  typedef enum logic [29:0] {
    S_INIT     = 30'b1 << 0,
    S_IDLE     = 30'b1 << 1,
    S_FIN      = 30'b1 << 2,
    S_A_CHK    = 30'b1 << 3,
    S_A_SPOP   = 30'b1 << 4,
    S_A_SFILLS = 30'b1 << 5,
    S_A_SPUSH1 = 30'b1 << 6,
    S_A_SPUSH2 = 30'b1 << 7,
    S_A_SNEXT  = 30'b1 << 8,
    S_A_POP    = 30'b1 << 9,
    S_A_UFILL  = 30'b1 << 10,
    S_F_RD     = 30'b1 << 11,
    S_F_CHK    = 30'b1 << 12,
    S_F_SCAN   = 30'b1 << 13,
    S_F_SCHK   = 30'b1 << 14,
    S_F_ORD    = 30'b1 << 15,
    S_F_MRG    = 30'b1 << 16,
    S_F_MCHK   = 30'b1 << 17,
    S_F_MU2    = 30'b1 << 18,
    S_F_MPUSH  = 30'b1 << 19,
    S_F_MFILL  = 30'b1 << 20,
    S_F_MNEXT  = 30'b1 << 21,
    S_R_LOOP   = 30'b1 << 22,
    S_R_NEXT   = 30'b1 << 23,
    S_U_START  = 30'b1 << 24,
    S_U_STEP   = 30'b1 << 25,
    S_U_EVAL   = 30'b1 << 26,
    S_P_A      = 30'b1 << 27,
    S_P_B      = 30'b1 << 28,
    S_FILL     = 30'b1 << 29
  } state_t;

  typedef struct packed {
    state_t st;
    logic   accept;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic bad_order;
    logic head_valid;
    logic src_found;
    logic split_more;
    logic free_used;
    logic scan_go;
    logic scan_body;
    logic mrg_go;
    logic bud_match;
    logic r_more;
    logic r_align;
    logic u_stop;
    logic u_hit;
    logic p_bad;
    logic fill_done;
  } stat_t;

  // order of a run: highest set bit, capped at the top order
  function automatic logic [ORD_W-1:0] msb_ord(input logic [CNT_W-1:0] c);
    logic [ORD_W-1:0] o;
    o = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (c[k]) o = (k > TOP_ORDER) ? ORD_W'(TOP_ORDER) : ORD_W'(k);
    end
    return o;
  endfunction

endpackage

// File: rtl/core/bpa_ram.sv
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bpa_datapath.sv
module bpa_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  bpa_pkg::cmd_t  cmd,
  input  bpa_pkg::req_t  in_data,
  output bpa_pkg::stat_t stat,
  output bpa_pkg::resp_t out_data
);
  import bpa_pkg::*;

  logic [ORD_W-1:0]  ord_r, j_r, v_r, u_ord_r, p_ord_r;
  logic [FI_W-1:0]   f_r, bud_r, g_r, u_tgt_r, p_frm_r, fill_base_r;
  logic [LW-1:0]     end_r, cur_r, ph_r, steps_r;
  logic [LW-1:0]     head_r [NUM_ORDERS];
  logic              bud_up_r;
  logic [CNT_W-1:0]  c_r, i_r, fill_cnt_r, fill_len_r, fill_half_r;
  logic [MARK_W-1:0] fill_mark_r;
  logic [AW-1:0]     init_cnt_r;
  resp_t             res_r, out_r;

  logic              m_we, n_we, p_we;
  logic [AW-1:0]     m_wa, m_ra, n_wa, p_wa, l_ra;
  logic [MARK_W-1:0] m_wd, rd_mark;
  logic [LW-1:0]     n_wd, p_wd, rd_next, rd_prev;

  logic [ORD_W-1:0]  hidx, src, f_ord;
  logic [LW-1:0]     head_rd;
  logic              found;
  logic [FI_W-1:0]   f_in, scan_addr, fill_addr, t_v, rem, up_f, dn_f, buddy, base;
  logic [BYTES_W:0]  rb_sum;
  logic [RS_W-1:0]   rs_end;
  logic [LW-1:0]     res_end;
  logic              r0, rt, init_al, at_head;

  bpa_ram #(.W(MARK_W), .D(NUM_FRAMES)) u_mark (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(rd_mark));
  bpa_ram #(.W(LW), .D(NUM_FRAMES)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(l_ra), .rdata(rd_next));
  bpa_ram #(.W(LW), .D(NUM_FRAMES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(l_ra), .rdata(rd_prev));

  // head read port selected by state; the source search below reads every head
  always_comb begin
    case (cmd.st)
      S_A_CHK, S_A_POP: hidx = ord_r;
      S_A_SPOP:         hidx = j_r;
      S_P_A:            hidx = p_ord_r;
      default:          hidx = u_ord_r;
    endcase
    head_rd = (hidx < ORD_W'(NUM_ORDERS)) ? head_r[hidx] : NIL;
  end

  // nearest larger order with a free block
  always_comb begin
    src   = '0;
    found = 1'b0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (ORD_W'(k) > ord_r && head_r[k] != NIL) begin
        src   = ORD_W'(k);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    f_in      = FI_W'(in_data.byte_addr >> PAGE_SH);
    rb_sum    = {1'b0, in_data.reserve_bytes} + (BYTES_W+1)'((1 << UNIT_SH) - 1);
    rs_end    = RS_W'(f_in) + (RS_W'(rb_sum >> UNIT_SH) << NUM_ORDERS);
    res_end   = (rs_end < RS_W'(NUM_FRAMES)) ? LW'(rs_end) : NIL;
    scan_addr = f_r + FI_W'(i_r);
    fill_addr = fill_base_r + FI_W'(fill_cnt_r);
    t_v       = FI_W'(1) << v_r;
    rem       = f_r & ((t_v << 1) - FI_W'(1));
    r0        = (rem == '0);
    rt        = (rem == t_v);
    up_f      = f_r + t_v;
    dn_f      = f_r - t_v;
    buddy     = r0 ? up_f : dn_f;
    base      = bud_up_r ? f_r : bud_r;
    f_ord     = msb_ord(c_r);
    init_al   = (init_cnt_r[TOP_ORDER-1:0] == '0);
    at_head   = (cur_r == head_rd);
  end

  always_comb begin
    stat.init_last  = (init_cnt_r == AW'(NUM_FRAMES - 1));
    stat.bad_order  = (ord_r >= ORD_W'(NUM_ORDERS));
    stat.head_valid = (head_rd != NIL);
    stat.src_found  = found;
    stat.split_more = ((j_r - ORD_W'(1)) > ord_r);
    stat.free_used  = (f_r < FI_W'(NUM_FRAMES)) && (rd_mark == MARK_USED);
    stat.scan_go    = (scan_addr < FI_W'(NUM_FRAMES)) && (i_r <= SCAN_LIM);
    stat.scan_body  = (rd_mark == MARK_BODY);
    stat.mrg_go     = (v_r < ORD_W'(TOP_ORDER)) &&
                      ((r0 && up_f < FI_W'(NUM_FRAMES)) || rt);
    stat.bud_match  = (rd_mark == MARK_W'(v_r));
    stat.r_more     = (g_r < FI_W'(end_r));
    stat.r_align    = (g_r[TOP_ORDER-1:0] == '0);
    stat.u_stop     = (steps_r == NIL) || (cur_r >= NIL);
    stat.u_hit      = (FI_W'(cur_r) == u_tgt_r);
    stat.p_bad      = (p_frm_r >= FI_W'(NUM_FRAMES));
    stat.fill_done  = (fill_cnt_r == fill_len_r);
  end

  // memory ports
  always_comb begin
    m_we = 1'b0;
    m_wa = f_r[AW-1:0];
    m_wd = MARK_USED;
    m_ra = f_r[AW-1:0];
    n_we = 1'b0;
    n_wa = init_cnt_r;
    n_wd = NIL;
    p_we = 1'b0;
    p_wa = init_cnt_r;
    p_wd = NIL;
    l_ra = cur_r[AW-1:0];
    case (cmd.st)
      S_INIT: begin
        m_we = 1'b1;
        m_wa = init_cnt_r;
        m_wd = init_al ? MARK_W'(TOP_ORDER) : MARK_BODY;
        n_we = 1'b1;
        n_wd = (init_al && init_cnt_r >= AW'(MAX_BLOCK)) ?
               LW'(init_cnt_r) - LW'(MAX_BLOCK) : NIL;
        p_we = 1'b1;
        p_wd = (init_al && (LW'(init_cnt_r) + LW'(MAX_BLOCK)) < NIL) ?
               LW'(init_cnt_r) + LW'(MAX_BLOCK) : NIL;
      end
      S_F_SCAN: m_ra = scan_addr[AW-1:0];
      S_F_MRG:  m_ra = buddy[AW-1:0];
      S_F_ORD: begin
        m_we = 1'b1;
        m_wd = MARK_W'(f_ord);
      end
      S_R_LOOP: begin
        m_we = stat.r_more;
        m_wa = g_r[AW-1:0];
      end
      S_FILL: begin
        m_we = !stat.fill_done && (fill_addr < FI_W'(NUM_FRAMES));
        m_wa = fill_addr[AW-1:0];
        m_wd = (fill_cnt_r == '0 || fill_cnt_r == fill_half_r) ? fill_mark_r : MARK_BODY;
      end
      S_P_A: begin
        n_we = !stat.p_bad;
        n_wa = p_frm_r[AW-1:0];
        n_wd = head_rd;
        p_we = !stat.p_bad;
        p_wa = p_frm_r[AW-1:0];
      end
      S_P_B: begin
        p_we = (ph_r < NIL);
        p_wa = ph_r[AW-1:0];
        p_wd = LW'(p_frm_r);
      end
      S_U_EVAL: begin
        p_wa = rd_next[AW-1:0];
        n_wa = rd_prev[AW-1:0];
        n_wd = rd_next;
        if (stat.u_hit) begin
          p_we = (rd_next < NIL);
          p_wd = at_head ? NIL : rd_prev;
          n_we = !at_head && (rd_prev < NIL);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        head_r[k] <= (k == TOP_ORDER) ? LW'(LAST_TOP) : NIL;
      end
    end else begin
      case (cmd.st)
        S_INIT: init_cnt_r <= init_cnt_r + AW'(1);
        S_IDLE: begin
          if (cmd.accept) begin
            ord_r <= in_data.order;
            f_r   <= f_in;
            g_r   <= f_in;
            end_r <= res_end;
            res_r <= '0;
          end
        end
        S_A_CHK: begin
          if (stat.bad_order) begin
            res_r.status <= ST_BAD_ORDER;
          end else if (!stat.head_valid) begin
            if (!found) res_r.status <= ST_NO_MEM;
            else        j_r <= src;
          end
        end
        S_A_SPOP: begin
          f_r     <= FI_W'(head_rd);
          u_ord_r <= j_r;
          u_tgt_r <= FI_W'(head_rd);
        end
        S_A_SFILLS: begin
          fill_base_r <= f_r;
          fill_cnt_r  <= '0;
          fill_len_r  <= CNT_W'(1) << j_r;
          fill_half_r <= CNT_W'(1) << (j_r - ORD_W'(1));
          fill_mark_r <= MARK_W'(j_r - ORD_W'(1));
        end
        S_A_SPUSH1: begin
          p_ord_r <= j_r - ORD_W'(1);
          p_frm_r <= f_r;
        end
        S_A_SPUSH2: begin
          p_ord_r <= j_r - ORD_W'(1);
          p_frm_r <= f_r + (FI_W'(1) << (j_r - ORD_W'(1)));
        end
        S_A_SNEXT: j_r <= j_r - ORD_W'(1);
        S_A_POP: begin
          f_r     <= FI_W'(head_rd);
          u_ord_r <= ord_r;
          u_tgt_r <= FI_W'(head_rd);
        end
        S_A_UFILL: begin
          fill_base_r      <= f_r;
          fill_cnt_r       <= '0;
          fill_len_r       <= CNT_W'(1) << ord_r;
          fill_half_r      <= '0;
          fill_mark_r      <= MARK_USED;
          res_r.block_addr <= ADDR_W'(f_r) << PAGE_SH;
        end
        S_F_CHK: begin
          c_r <= CNT_W'(1);
          i_r <= CNT_W'(1);
        end
        S_F_SCHK: begin
          if (stat.scan_body) begin
            c_r <= c_r + CNT_W'(1);
            i_r <= i_r + CNT_W'(1);
          end
        end
        S_F_ORD: begin
          res_r.freed_order <= f_ord;
          v_r     <= f_ord;
          p_ord_r <= f_ord;
          p_frm_r <= f_r;
        end
        S_F_MRG: begin
          bud_r    <= buddy;
          bud_up_r <= r0;
        end
        S_F_MCHK: begin
          u_ord_r <= v_r;
          u_tgt_r <= bud_r;
        end
        S_F_MU2: u_tgt_r <= f_r;
        S_F_MPUSH: begin
          f_r     <= base;
          p_ord_r <= v_r + ORD_W'(1);
          p_frm_r <= base;
        end
        S_F_MFILL: begin
          fill_base_r <= f_r;
          fill_cnt_r  <= '0;
          fill_len_r  <= CNT_W'(2) << v_r;
          fill_half_r <= '0;
          fill_mark_r <= MARK_W'(v_r + ORD_W'(1));
        end
        S_F_MNEXT: v_r <= v_r + ORD_W'(1);
        S_R_LOOP: begin
          if (stat.r_more) begin
            if (stat.r_align) begin
              u_ord_r <= ORD_W'(TOP_ORDER);
              u_tgt_r <= g_r;
            end else begin
              g_r <= g_r + FI_W'(1);
            end
          end
        end
        S_R_NEXT: g_r <= g_r + FI_W'(1);
        S_U_START: begin
          cur_r   <= head_rd;
          steps_r <= '0;
        end
        S_U_EVAL: begin
          if (!stat.u_hit) begin
            cur_r   <= rd_next;
            steps_r <= steps_r + LW'(1);
          end else if (at_head) begin
            head_r[u_ord_r] <= rd_next;
          end
        end
        S_P_A: begin
          if (!stat.p_bad) begin
            ph_r            <= head_rd;
            head_r[p_ord_r] <= LW'(p_frm_r);
          end
        end
        S_FILL: if (!stat.fill_done) fill_cnt_r <= fill_cnt_r + CNT_W'(1);
        default: ;
      endcase
      if (cmd.load_out) out_r <= res_r;
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st == S_U_EVAL |-> cur_r < NIL)
    else $error("list walk evaluated an empty link");

  a_init_top_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st == S_IDLE && $past(cmd.st == S_INIT) |-> head_r[TOP_ORDER] != NIL)
    else $error("top order list empty after clearing pass");
`endif

endmodule

// File: rtl/core/bpa_ctrl.sv
module bpa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [bpa_pkg::FUNC_W-1:0] in_func,
  input  logic                      out_stall,
  input  bpa_pkg::stat_t            stat,
  output bpa_pkg::cmd_t             cmd,
  output logic                      in_stall,
  output logic                      out_valid
);
  import bpa_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, load_out;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_INIT: if (stat.init_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_ALLOC:   state_nxt = S_A_CHK;
            FN_FREE:    state_nxt = S_F_RD;
            FN_RESERVE: state_nxt = S_R_LOOP;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_A_CHK: begin
        if (stat.bad_order)       state_nxt = S_FIN;
        else if (stat.head_valid) state_nxt = S_A_POP;
        else if (!stat.src_found) state_nxt = S_FIN;
        else                      state_nxt = S_A_SPOP;
      end
      S_A_SPOP: begin
        state_nxt = S_U_START;
        ret_nxt   = S_A_SFILLS;
      end
      S_A_SFILLS: begin
        state_nxt = S_FILL;
        ret_nxt   = S_A_SPUSH1;
      end
      S_A_SPUSH1: begin
        state_nxt = S_P_A;
        ret_nxt   = S_A_SPUSH2;
      end
      S_A_SPUSH2: begin
        state_nxt = S_P_A;
        ret_nxt   = S_A_SNEXT;
      end
      S_A_SNEXT: state_nxt = stat.split_more ? S_A_SPOP : S_A_POP;
      S_A_POP: begin
        state_nxt = S_U_START;
        ret_nxt   = S_A_UFILL;
      end
      S_A_UFILL: begin
        state_nxt = S_FILL;
        ret_nxt   = S_FIN;
      end
      S_F_RD:   state_nxt = S_F_CHK;
      S_F_CHK:  state_nxt = stat.free_used ? S_F_SCAN : S_FIN;
      S_F_SCAN: state_nxt = stat.scan_go ? S_F_SCHK : S_F_ORD;
      S_F_SCHK: state_nxt = stat.scan_body ? S_F_SCAN : S_F_ORD;
      S_F_ORD: begin
        state_nxt = S_P_A;
        ret_nxt   = S_F_MRG;
      end
      S_F_MRG: state_nxt = stat.mrg_go ? S_F_MCHK : S_FIN;
      S_F_MCHK: begin
        if (stat.bud_match) begin
          state_nxt = S_U_START;
          ret_nxt   = S_F_MU2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_F_MU2: begin
        state_nxt = S_U_START;
        ret_nxt   = S_F_MPUSH;
      end
      S_F_MPUSH: begin
        state_nxt = S_P_A;
        ret_nxt   = S_F_MFILL;
      end
      S_F_MFILL: begin
        state_nxt = S_FILL;
        ret_nxt   = S_F_MNEXT;
      end
      S_F_MNEXT: state_nxt = S_F_MRG;
      S_R_LOOP: begin
        if (!stat.r_more) begin
          state_nxt = S_FIN;
        end else if (stat.r_align) begin
          state_nxt = S_U_START;
          ret_nxt   = S_R_NEXT;
        end
      end
      S_R_NEXT:  state_nxt = S_R_LOOP;
      S_U_START: state_nxt = S_U_STEP;
      S_U_STEP:  state_nxt = stat.u_stop ? ret_r : S_U_EVAL;
      S_U_EVAL:  state_nxt = stat.u_hit ? ret_r : S_U_STEP;
      S_P_A:     state_nxt = stat.p_bad ? ret_r : S_P_B;
      S_P_B:     state_nxt = ret_r;
      S_FILL:    if (stat.fill_done) state_nxt = ret_r;
      S_FIN:     if (load_out) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.st       = state_r;
  assign cmd.accept   = accept;
  assign cmd.load_out = load_out;
  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;

`ifndef SYNTHESIS
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before first finished");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");

  a_sub_return: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_U_STEP |-> ret_r != S_U_START && ret_r != S_FILL && ret_r != S_P_A)
    else $error("list walk has a bad return point");
`endif

endmodule

// File: rtl/core/buddy_page_allocator.sv
// buddy page allocator, one request at a time, one result per request
// after reset a clearing pass over all NUM_FRAMES frames (1024) sets marks and links; no request taken
// the mark/link ram sweeps set how long a request takes: free scans up to 128 marks one by one,
// each list unlink walks the list entry by entry, each split/merge writes 2^order marks
// an allocate from a nonempty list unlinks the list head and writes 2^order marks
// the output register lets the next request start while a result waits to be taken
module buddy_page_allocator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bpa_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bpa_pkg::resp_t out_data
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  bpa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
